// File: sv/wto_pkg.sv
// Types, constants and helpers shared by the wavetable oscillator modules.
// No dependencies.
package wto_pkg;

  localparam int TABLE_LEN = 1024;
  localparam int NUM_NOTES = 128;
  localparam int NUM_WAVES = 3;

  localparam int FRAC_W      = 16;
  localparam int IDX_W       = $clog2(TABLE_LEN);
  localparam int PHASE_W     = IDX_W + FRAC_W;
  localparam int SAMPLE_W    = 16;
  localparam int WAVE_W      = 2;
  localparam int NOTE_W      = 7;
  localparam int STORE_DEPTH = NUM_WAVES * NUM_NOTES * TABLE_LEN;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 26;

  localparam int CMD_DEPTH   = 4;
  localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_TICK        = 2'd0,
    REQ_LOAD        = 2'd1,
    REQ_PHASE_RESET = 2'd2
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAVE = 2'd0,
    CFG_NOTE = 2'd1,
    CFG_INC  = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [ADDR_W-1:0]   addr0;
    logic [ADDR_W-1:0]   addr1;
    logic [SAMPLE_W-1:0] data;
    logic [FRAC_W-1:0]   frac;
    logic                sel_ok;
  } cmd_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic [WAVE_W-1:0] wave,
                                                   input logic [NOTE_W-1:0] note,
                                                   input logic [IDX_W-1:0]  idx);
    int a;
    a = (int'(wave) * NUM_NOTES + int'(note)) * TABLE_LEN + int'(idx);
    return ADDR_W'(a);
  endfunction

endpackage

// File: sv/wavetable_oscillator_top.sv
// Wavetable oscillator with linear interpolation between neighbouring entries.
// Tick path: command queue, table read registers, product register, result queue.
// Throughput: one item per cycle; the back end issues one table command per cycle
// while results have room; the input stalls once the four-entry command queue fills.
// Reset: synchronous; clears phase, registers and queues, leaves the table store as is.
// Depends on wto_pkg, wto_front, wto_cmd_queue, wto_back, wto_out_queue.
module wavetable_oscillator_top import wto_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            req_type,
  input  logic [WAVE_W-1:0]     load_wave,
  input  logic [NOTE_W-1:0]     load_note,
  input  logic [IDX_W-1:0]      load_index,
  input  logic signed [SAMPLE_W-1:0] load_value,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [SAMPLE_W-1:0] sample_out
);

  logic                 accept;
  logic                 cmd_push;
  cmd_t                 cmd_in;
  logic                 cmd_empty;
  logic                 cmd_pop;
  cmd_t                 cmd_head;
  logic [OUT_CNT_W-1:0] out_count;
  logic                 res_push;
  logic [SAMPLE_W-1:0]  res_sample;
  logic [SAMPLE_W-1:0]  out_head;

  assign cfg_ready  = 1'b1;
  assign accept     = push && !full;
  assign sample_out = out_head;

  wto_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .req_type   (req_type),
    .load_wave  (load_wave),
    .load_note  (load_note),
    .load_index (load_index),
    .load_value (load_value),
    .cmd_push   (cmd_push),
    .cmd        (cmd_in)
  );

  wto_cmd_queue u_cmd_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .push_cmd (cmd_in),
    .full     (full),
    .pop      (cmd_pop),
    .empty    (cmd_empty),
    .head     (cmd_head)
  );

  wto_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_empty  (cmd_empty),
    .cmd        (cmd_head),
    .cmd_pop    (cmd_pop),
    .out_count  (out_count),
    .res_push   (res_push),
    .res_sample (res_sample)
  );

  wto_out_queue u_out_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (res_push),
    .push_sample (res_sample),
    .pop         (pop),
    .empty       (empty),
    .head        (out_head),
    .count       (out_count)
  );

endmodule

// File: sv/wto_front.sv
// Front end: configuration registers, phase accumulator and item classification.
// Depends on wto_pkg.
module wto_front import wto_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic [1:0]            req_type,
  input  logic [WAVE_W-1:0]     load_wave,
  input  logic [NOTE_W-1:0]     load_note,
  input  logic [IDX_W-1:0]      load_index,
  input  logic [SAMPLE_W-1:0]   load_value,
  output logic                  cmd_push,
  output cmd_t                  cmd
);

  logic [WAVE_W-1:0]  wave_select;
  logic [NOTE_W-1:0]  note_select;
  logic [PHASE_W-1:0] phase_increment;
  logic [PHASE_W-1:0] phase_acc;
  logic [PHASE_W-1:0] phase_acc_next;
  logic [IDX_W-1:0]   idx0;
  logic [IDX_W-1:0]   idx1;
  logic               load_ok;
  logic               sel_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_select     <= '0;
      note_select     <= '0;
      phase_increment <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WAVE: wave_select     <= cfg_data[WAVE_W-1:0];
        CFG_NOTE: note_select     <= cfg_data[NOTE_W-1:0];
        CFG_INC:  phase_increment <= cfg_data[PHASE_W-1:0];
        default:  ;
      endcase
    end
  end

  assign idx0    = phase_acc[PHASE_W-1:FRAC_W];
  assign idx1    = (32'(idx0) == TABLE_LEN - 1) ? '0 : idx0 + IDX_W'(1);
  assign sel_ok  = (32'(wave_select) < NUM_WAVES) && (32'(note_select) < NUM_NOTES);
  assign load_ok = (32'(load_wave) < NUM_WAVES) && (32'(load_note) < NUM_NOTES) &&
                   (32'(load_index) < TABLE_LEN);

  always_comb begin
    phase_acc_next = phase_acc;
    cmd_push       = 1'b0;
    cmd.kind       = CMD_TICK;
    cmd.addr0      = store_addr(wave_select, note_select, idx0);
    cmd.addr1      = store_addr(wave_select, note_select, idx1);
    cmd.data       = load_value;
    cmd.frac       = phase_acc[FRAC_W-1:0];
    cmd.sel_ok     = sel_ok;
    if (accept) begin
      unique case (req_type)
        REQ_TICK: begin
          phase_acc_next = phase_acc + phase_increment;
          cmd_push       = 1'b1;
        end
        REQ_LOAD: begin
          cmd.kind  = CMD_WRITE;
          cmd.addr0 = store_addr(load_wave, load_note, load_index);
          cmd_push  = load_ok;
        end
        REQ_PHASE_RESET: phase_acc_next = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc <= '0;
    end else begin
      phase_acc <= phase_acc_next;
    end
  end

endmodule

// File: sv/wto_cmd_queue.sv
// Short command queue between the front end and the table back end.
// Depends on wto_pkg.
module wto_cmd_queue import wto_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t                 entries [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (32'(count) == CMD_DEPTH);
  assign empty   = (count == '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + CMD_PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + CMD_PTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + CMD_CNT_W'(1);
        2'b01:   count <= count - CMD_CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

// File: sv/wto_out_queue.sv
// Result queue holding interpolated samples until they are taken.
// Depends on wto_pkg.
module wto_out_queue import wto_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [SAMPLE_W-1:0]  push_sample,
  input  logic                 pop,
  output logic                 empty,
  output logic [SAMPLE_W-1:0]  head,
  output logic [OUT_CNT_W-1:0] count
);

  logic [SAMPLE_W-1:0]  entries [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic                 do_pop;

  assign empty  = (count == '0);
  assign head   = entries[rd_ptr];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      case ({push, do_pop})
        2'b10:   count <= count + OUT_CNT_W'(1);
        2'b01:   count <= count - OUT_CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

// File: sv/wto_back.sv
// Back end: table store, two-entry read, interpolation pipeline.
// Depends on wto_pkg; feeds wto_out_queue.
module wto_back import wto_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_empty,
  input  cmd_t                 cmd,
  output logic                 cmd_pop,
  input  logic [OUT_CNT_W-1:0] out_count,
  output logic                 res_push,
  output logic [SAMPLE_W-1:0]  res_sample
);

  logic [SAMPLE_W-1:0] mem [STORE_DEPTH];

  logic                       credit_ok;
  logic                       wr_en;
  logic                       rd_en;
  logic                       v1;
  logic signed [SAMPLE_W-1:0] rd0;
  logic signed [SAMPLE_W-1:0] rd1;
  logic [FRAC_W-1:0]          frac1;
  logic                       ok1;
  logic                       v2;
  logic signed [SAMPLE_W-1:0] s0_2;
  logic signed [32:0]         prod;
  logic                       ok2;
  logic signed [SAMPLE_W:0]   diff;
  logic signed [FRAC_W:0]     frac_s;
  logic signed [33:0]         prod_full;
  logic [SAMPLE_W:0]          sum;

  assign credit_ok = (32'(out_count) + 32'(v1) + 32'(v2)) < OUT_DEPTH;
  assign cmd_pop   = !cmd_empty && ((cmd.kind == CMD_WRITE) || credit_ok);
  assign wr_en     = cmd_pop && (cmd.kind == CMD_WRITE);
  assign rd_en     = cmd_pop && (cmd.kind == CMD_TICK);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cmd.addr0] <= cmd.data;
    end
    if (rd_en) begin
      rd0 <= mem[cmd.addr0];
      rd1 <= mem[cmd.addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      frac1 <= cmd.frac;
      ok1   <= cmd.sel_ok;
    end
  end

  assign diff      = {rd1[SAMPLE_W-1], rd1} - {rd0[SAMPLE_W-1], rd0};
  assign frac_s    = {1'b0, frac1};
  assign prod_full = diff * frac_s;

  always_ff @(posedge clk) begin
    if (v1) begin
      s0_2 <= rd0;
      prod <= prod_full[32:0];
      ok2  <= ok1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= rd_en;
      v2 <= v1;
    end
  end

  assign sum        = {s0_2[SAMPLE_W-1], s0_2} + prod[32:FRAC_W];
  assign res_push   = v2;
  assign res_sample = ok2 ? sum[SAMPLE_W-1:0] : '0;

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for wavetable_oscillator_top: a directed table of items, then random
// table loads, ticks and phase resets; samples checked vs an in-bench predictor or table value.
// Depends on wto_pkg and the oscillator RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wto_pkg::*;

  localparam logic [1:0]           REQ_UNKNOWN  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;
  localparam int                   SEGMENTS     = 12;
  localparam int                   SEG_ITEMS    = 100;
  localparam int                   HOLD_CYCLES  = 200;
  localparam int                   HOLD_SPACING = 500;
  localparam int                   DRAIN_CYCLES = 8;
  localparam int                   REPORT_LIMIT = 10;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [1:0]            req;
    logic [WAVE_W-1:0]     wave;
    logic [NOTE_W-1:0]     note;
    logic [IDX_W-1:0]      idx;
    logic [SAMPLE_W-1:0]   val;
    logic                  typed;
    logic [SAMPLE_W-1:0]   want;
  } plan_row_t;

  logic                         clk        = 1'b0;
  logic                         rst        = 1'b1;
  logic                         cfg_valid  = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index  = '0;
  logic [CFG_DATA_W-1:0]        cfg_data   = '0;
  logic                         push       = 1'b0;
  logic                         full;
  logic [1:0]                   req_type   = '0;
  logic [WAVE_W-1:0]            load_wave  = '0;
  logic [NOTE_W-1:0]            load_note  = '0;
  logic [IDX_W-1:0]             load_index = '0;
  logic signed [SAMPLE_W-1:0]   load_value = '0;
  logic                         empty;
  logic                         pop        = 1'b0;
  logic signed [SAMPLE_W-1:0]   sample_out;

  logic [PHASE_W-1:0]           osc_phase  = '0;
  logic [WAVE_W-1:0]            sel_wave   = '0;
  logic [NOTE_W-1:0]            sel_note   = '0;
  logic [PHASE_W-1:0]           step_size  = '0;
  bit signed [SAMPLE_W-1:0]     wave_mem     [STORE_DEPTH];
  bit                           wave_mem_set [STORE_DEPTH];
  logic signed [SAMPLE_W-1:0]   sample_queue [$];

  int items_sent    = 0;
  int items_done    = 0;
  int results_seen  = 0;
  int faults        = 0;
  int stall_cycles  = 0;
  int settings_used = 0;
  int tx_idle_pct   = 14;
  int rx_idle_pct   = 57;
  int hold_left     = 0;
  int next_hold_at  = 150;
  int holds_done    = 0;

  wavetable_oscillator_top u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAIL wavetable_oscillator_top");
    $finish;
  end

  function automatic int mem_addr(logic [WAVE_W-1:0] w, logic [NOTE_W-1:0] n,
                                  logic [IDX_W-1:0] i);
    int row;
    row = int'(w) * NUM_NOTES + int'(n);
    return row * TABLE_LEN + int'(i);
  endfunction

  // interpolate between the current entry and its neighbour, then advance the phase
  function automatic logic [SAMPLE_W-1:0] tick_sample();
    logic [IDX_W-1:0]    i0, i1;
    longint              s0, s1, prod;
    logic [SAMPLE_W-1:0] r;
    i0 = osc_phase[PHASE_W-1:FRAC_W];
    i1 = (int'(i0) == TABLE_LEN - 1) ? '0 : i0 + 1'b1;
    r  = '0;
    if (sel_wave < NUM_WAVES) begin
      s0   = wave_mem[mem_addr(sel_wave, sel_note, i0)];
      s1   = wave_mem[mem_addr(sel_wave, sel_note, i1)];
      prod = (s1 - s0) * longint'(osc_phase[FRAC_W-1:0]);
      r    = SAMPLE_W'(s0 + (prod >>> FRAC_W));
    end
    osc_phase = osc_phase + step_size;
    return r;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic plan_row_t load_row(logic [WAVE_W-1:0] w, logic [NOTE_W-1:0] n,
                                         logic [IDX_W-1:0] i, logic [SAMPLE_W-1:0] v);
    plan_row_t r;
    r      = '0;
    r.req  = REQ_LOAD;
    r.wave = w;
    r.note = n;
    r.idx  = i;
    r.val  = v;
    return r;
  endfunction

  function automatic plan_row_t tick_row(logic typed, logic [SAMPLE_W-1:0] want);
    plan_row_t r;
    r       = '0;
    r.req   = REQ_TICK;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t bare_row(logic [1:0] req);
    plan_row_t r;
    r     = '0;
    r.req = req;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    plan_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = v;
    return r;
  endfunction

  task automatic send_item(input logic [1:0] req, input logic [WAVE_W-1:0] w,
                           input logic [NOTE_W-1:0] n, input logic [IDX_W-1:0] i,
                           input logic [SAMPLE_W-1:0] v, input logic typed,
                           input logic [SAMPLE_W-1:0] want);
    logic [SAMPLE_W-1:0] pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      push <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    push       <= 1'b1;
    req_type   <= req;
    load_wave  <= w;
    load_note  <= n;
    load_index <= i;
    load_value <= v;
    @(posedge clk);
    while (full) begin
      stall_cycles++;
      @(posedge clk);
    end
    items_sent++;
    case (req)
      REQ_TICK: begin
        pred = tick_sample();
        sample_queue.push_back(typed ? want : pred);
        items_done++;
      end
      REQ_LOAD: begin
        if (w < NUM_WAVES) begin
          wave_mem[mem_addr(w, n, i)]     = v;
          wave_mem_set[mem_addr(w, n, i)] = 1'b1;
          items_done++;
        end
      end
      REQ_PHASE_RESET: begin
        osc_phase = '0;
        items_done++;
      end
      default: ;
    endcase
  endtask

  // load the two entries the next tick reads if they were never written
  task automatic fill_gaps();
    logic [IDX_W-1:0] i0, i1;
    if (sel_wave < NUM_WAVES) begin
      i0 = osc_phase[PHASE_W-1:FRAC_W];
      i1 = i0 + 1'b1;
      if (!wave_mem_set[mem_addr(sel_wave, sel_note, i0)])
        send_item(REQ_LOAD, sel_wave, sel_note, i0, rand_value(), 1'b0, '0);
      if (!wave_mem_set[mem_addr(sel_wave, sel_note, i1)])
        send_item(REQ_LOAD, sel_wave, sel_note, i1, rand_value(), 1'b0, '0);
    end
  endtask

  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (sample_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_WAVE: sel_wave  = v[WAVE_W-1:0];
      CFG_NOTE: sel_note  = v[NOTE_W-1:0];
      CFG_INC:  step_size = v[PHASE_W-1:0];
      default:  ;
    endcase
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    settle();
    write_reg(idx, v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_osc(input logic [WAVE_W-1:0] w, input logic [NOTE_W-1:0] n,
                             input logic [CFG_DATA_W-1:0] inc);
    settle();
    write_reg(CFG_WAVE, CFG_DATA_W'(w));
    write_reg(CFG_NOTE, CFG_DATA_W'(n));
    write_reg(CFG_INC, inc);
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else if (results_seen >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_SPACING;
      holds_done   <= holds_done + 1;
      pop          <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    logic signed [SAMPLE_W-1:0] want;
    if (!rst && pop && !empty) begin
      results_seen = results_seen + 1;
      if (sample_queue.size() == 0) begin
        faults++;
        if (faults <= REPORT_LIMIT)
          $display("unexpected sample_out %0d at %0t", sample_out, $time);
      end else begin
        want = sample_queue.pop_front();
        if (sample_out !== want) begin
          faults++;
          if (faults <= REPORT_LIMIT)
            $display("mismatch on sample_out: got %0d, want %0d at %0t",
                     sample_out, want, $time);
        end
      end
    end
  end

  initial begin
    plan_row_t             plan [$];
    plan_row_t             r;
    int                    seg;
    int                    seg_start;
    int                    roll;
    logic [IDX_W-1:0]      near;
    logic [WAVE_W-1:0]     w;
    logic [NOTE_W-1:0]     n;
    logic [CFG_DATA_W-1:0] inc;

    plan.push_back(load_row(2'd0, 7'd0, 10'd0, 16'h7FFF));
    plan.push_back(load_row(2'd0, 7'd0, 10'd1, 16'h8000));
    plan.push_back(tick_row(1'b1, 16'h7FFF));
    plan.push_back(load_row(WAVE_W'(NUM_WAVES), 7'd0, 10'd0, 16'h0000));
    plan.push_back(tick_row(1'b1, 16'h7FFF));
    plan.push_back(bare_row(REQ_UNKNOWN));
    plan.push_back(load_row(2'd0, 7'd0, 10'd1023, 16'h8000));
    plan.push_back(reg_row(CFG_INC, 26'h0008000));
    plan.push_back(tick_row(1'b1, 16'h7FFF));
    plan.push_back(tick_row(1'b0, '0));
    plan.push_back(bare_row(REQ_PHASE_RESET));
    plan.push_back(tick_row(1'b1, 16'h7FFF));
    plan.push_back(reg_row(CFG_INC, 26'h3FFFFFF));
    plan.push_back(bare_row(REQ_PHASE_RESET));
    plan.push_back(tick_row(1'b1, 16'h7FFF));
    plan.push_back(tick_row(1'b0, '0));
    plan.push_back(reg_row(CFG_SPARE, 26'h3FFFFFF));
    plan.push_back(reg_row(CFG_WAVE, 26'd2));
    plan.push_back(reg_row(CFG_NOTE, 26'd127));
    plan.push_back(reg_row(CFG_INC, 26'h0010000));
    plan.push_back(load_row(2'd2, 7'd127, 10'd0, 16'd100));
    plan.push_back(load_row(2'd2, 7'd127, 10'd1, 16'hFF9C));
    plan.push_back(load_row(2'd2, 7'd127, 10'd2, 16'd7));
    plan.push_back(bare_row(REQ_PHASE_RESET));
    plan.push_back(tick_row(1'b1, 16'd100));
    plan.push_back(tick_row(1'b0, '0));
    plan.push_back(reg_row(CFG_WAVE, 26'd3));
    plan.push_back(tick_row(1'b1, 16'd0));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      r = plan[k];
      if (r.is_cfg)
        write_one(r.reg_idx, r.reg_val);
      else
        send_item(r.req, r.wave, r.note, r.idx, r.val, r.typed, r.want);
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 4)
        0: begin
          tx_idle_pct = 14;
          rx_idle_pct = 57;
        end
        1: begin
          tx_idle_pct = 57;
          rx_idle_pct = 14;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      w = ($urandom_range(9) == 0) ? WAVE_W'(NUM_WAVES) : WAVE_W'($urandom_range(NUM_WAVES - 1));
      case ($urandom_range(3))
        0:       n = '0;
        1:       n = '1;
        default: n = NOTE_W'($urandom());
      endcase
      case ($urandom_range(5))
        0:       inc = CFG_DATA_W'($urandom());
        1:       inc = '1;
        2:       inc = 26'h0010000;
        default: inc = CFG_DATA_W'($urandom_range(20'hFFFFF));
      endcase
      case (seg)
        0:       program_osc(2'd2, '1, '1);
        1:       program_osc(2'd0, '0, '0);
        6:       program_osc(WAVE_W'(NUM_WAVES), n, inc);
        default: program_osc(w, n, inc);
      endcase

      seg_start = items_done;
      while (items_done - seg_start < SEG_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 50) begin
          fill_gaps();
          send_item(REQ_TICK, WAVE_W'($urandom()), NOTE_W'($urandom()), IDX_W'($urandom()),
                    SAMPLE_W'($urandom()), 1'b0, '0);
        end else if (roll < 80) begin
          roll = $urandom_range(99);
          near = osc_phase[PHASE_W-1:FRAC_W] + IDX_W'($urandom_range(3));
          if (roll < 60)
            send_item(REQ_LOAD, sel_wave, sel_note, near, rand_value(), 1'b0, '0);
          else if (roll < 85)
            send_item(REQ_LOAD, sel_wave, sel_note, IDX_W'($urandom()), rand_value(), 1'b0, '0);
          else
            send_item(REQ_LOAD, WAVE_W'($urandom()), NOTE_W'($urandom()), IDX_W'($urandom()),
                      rand_value(), 1'b0, '0);
        end else if (roll < 88) begin
          send_item(REQ_PHASE_RESET, WAVE_W'($urandom()), NOTE_W'($urandom()),
                    IDX_W'($urandom()), SAMPLE_W'($urandom()), 1'b0, '0);
        end else if (roll < 94) begin
          send_item(REQ_UNKNOWN, WAVE_W'($urandom()), NOTE_W'($urandom()),
                    IDX_W'($urandom()), SAMPLE_W'($urandom()), 1'b0, '0);
        end else begin
          send_item(REQ_LOAD, WAVE_W'(NUM_WAVES), NOTE_W'($urandom()), IDX_W'($urandom()),
                    SAMPLE_W'($urandom()), 1'b0, '0);
        end
      end
    end

    @(negedge clk);
    push <= 1'b0;
    while (sample_queue.size() != 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    faults += sample_queue.size();

    $display("Covered %0d accepted items (%0d effective), %0d samples checked, %0d settings.",
             items_sent, items_done, results_seen, settings_used);
    $display("Input held off by full for %0d cycles; output drain paused %0d times.",
             stall_cycles, holds_done);
    if (faults == 0) begin
      $display("PASS wavetable_oscillator_top");
    end else begin
      $display("FAIL wavetable_oscillator_top");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/wto_pkg.sv
sv/wto_front.sv
sv/wto_cmd_queue.sv
sv/wto_out_queue.sv
sv/wto_back.sv
sv/wavetable_oscillator_top.sv
tb/sv/testbench.sv
